/* rtl/prr_pkg.sv */
// Package for the panel request responder: sizes, codes, types and the
// seven-segment table. Used by every module of the block.
package prr_pkg;

  // Request and response framing
  localparam int DISPLAY_DIGITS = 3;
  localparam int REQUEST_LENGTH = 4;
  localparam logic [7:0] HEADER_BYTE    = 8'hA5;
  localparam logic [7:0] RESPONSE_START = 8'h5A;
  localparam logic [7:0] DOT_BIT        = 8'h80;

  // Receive byte counter and response byte index widths
  localparam int CNT_W = 3;
  localparam int IDX_W = 4;
  localparam logic [CNT_W-1:0] LAST_DATA_CNT = CNT_W'(REQUEST_LENGTH - 1);
  localparam logic [IDX_W-1:0] STATUS_IDX    = IDX_W'(DISPLAY_DIGITS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX      = IDX_W'(DISPLAY_DIGITS + 2);

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT0_CHAR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT1_CHAR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT2_CHAR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOT_MASK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ON   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_IND   = 3'd5;

  // Response sequencer states
  typedef enum logic {
    B_IDLE,
    B_SEND
  } back_state_t;

  // Completed request, handed from front to back
  typedef struct packed {
    logic        err;
    logic [15:0] code;
  } cmd_t;

  // Display settings
  typedef struct packed {
    logic [6:0] digit0_char;
    logic [6:0] digit1_char;
    logic [6:0] digit2_char;
    logic [2:0] dot_mask;
    logic       screen_on;
    logic       timer_indicator;
  } cfg_t;

  // Seven-segment code of an ASCII character; unknown characters are blank
  function automatic logic [7:0] seg_code(input logic [6:0] c);
    logic [7:0] s;
    case (c)
      7'h30: s = 8'h3f;
      7'h31: s = 8'h06;
      7'h32: s = 8'h5b;
      7'h33: s = 8'h4f;
      7'h34: s = 8'h66;
      7'h35: s = 8'h6d;
      7'h36: s = 8'h7d;
      7'h37: s = 8'h07;
      7'h38: s = 8'h7f;
      7'h39: s = 8'h6f;
      7'h20: s = 8'h00;
      7'h2d: s = 8'h40;
      7'h41, 7'h61: s = 8'h77;
      7'h45, 7'h65: s = 8'h79;
      7'h46, 7'h66: s = 8'h71;
      7'h48, 7'h68: s = 8'h76;
      7'h4c, 7'h6c: s = 8'h38;
      7'h54, 7'h74: s = 8'h31;
      7'h52, 7'h72: s = 8'h50;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

/* rtl/prr_front.sv */
// Request parser: hunts for the header, collects the request bytes with a
// running sum and pushes one command per completed request. Uses prr_pkg.
module prr_front
  import prr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic             phase;
  logic [CNT_W-1:0] cnt;
  logic [7:0]       sum;
  logic [7:0]       code_hi;
  logic [7:0]       code_lo;
  logic             take;
  logic             done;

  // Any byte waits only while the queue is full
  assign in_ready = ~q_full;
  assign take     = in_valid & in_ready;
  assign done     = phase & (cnt >= LAST_DATA_CNT);
  assign q_push   = take & done;

  // Command for the back end; request code bytes exist only for long requests
  always_comb begin
    q_cmd.err  = (sum != in_byte);
    q_cmd.code = {((REQUEST_LENGTH > 2) ? code_hi : 8'h00),
                  ((REQUEST_LENGTH > 3) ? code_lo : 8'h00)};
  end

  // Receive phase and byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      cnt   <= '0;
    end else if (take) begin
      if (!phase) begin
        if (in_byte == HEADER_BYTE) begin
          phase <= 1'b1;
          cnt   <= '0;
        end
      end else if (done) begin
        phase <= 1'b0;
        cnt   <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Running sum and request code capture
  always_ff @(posedge clk) begin
    if (take) begin
      if (!phase) begin
        sum <= 8'h00;
      end else if (!done) begin
        sum <= sum + in_byte;
        if (cnt == CNT_W'(1)) code_hi <= in_byte;
        if (cnt == CNT_W'(2)) code_lo <= in_byte;
      end
    end
  end

endmodule

/* rtl/prr_queue.sv */
// Two-entry command queue between the parser and the response sequencer.
// Uses prr_pkg for the command type and depth.
module prr_queue
  import prr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  cmd_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full  = (count == Q_CNT_W'(Q_DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/prr_back.sv */
// Response sequencer: turns one command into an error item or the response
// frame, one item per cycle into an output register while not stalled. Uses prr_pkg.
module prr_back
  import prr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_err,
  output logic [15:0] out_code
);

  back_state_t      state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] dig;
  logic [7:0]       sum, sum_next;
  logic [7:0]       digit_val;
  logic [7:0]       status;
  logic [7:0]       cur_byte;
  logic             advance;
  logic             out_valid_next;
  logic [7:0]       out_byte_next;
  logic             out_last_next;
  logic             out_err_next;
  logic [15:0]      out_code_next;

  assign advance = ~out_valid | out_ready;
  assign dig     = idx - 1'b1;
  assign status  = {3'b000, cfg.screen_on, 3'b000, cfg.timer_indicator};

  // Digit byte for the current index; digits past the third are blank
  always_comb begin
    case (dig)
      IDX_W'(0): digit_val = seg_code(cfg.digit0_char) | (cfg.dot_mask[0] ? DOT_BIT : 8'h00);
      IDX_W'(1): digit_val = seg_code(cfg.digit1_char) | (cfg.dot_mask[1] ? DOT_BIT : 8'h00);
      IDX_W'(2): digit_val = seg_code(cfg.digit2_char) | (cfg.dot_mask[2] ? DOT_BIT : 8'h00);
      default:   digit_val = 8'h00;
    endcase
  end

  // Frame byte by position: digits, then status, then checksum
  always_comb begin
    if (idx < STATUS_IDX) begin
      cur_byte = digit_val;
    end else if (idx == STATUS_IDX) begin
      cur_byte = status;
    end else begin
      cur_byte = sum;
    end
  end

  // Next state and output register load
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    sum_next       = sum;
    q_pop          = 1'b0;
    out_valid_next = out_valid;
    out_byte_next  = out_byte;
    out_last_next  = out_last;
    out_err_next   = out_err;
    out_code_next  = out_code;
    if (advance) begin
      out_valid_next = 1'b0;
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            q_pop          = 1'b1;
            out_valid_next = 1'b1;
            out_code_next  = q_head.code;
            if (q_head.err) begin
              out_byte_next = 8'h00;
              out_last_next = 1'b1;
              out_err_next  = 1'b1;
            end else begin
              out_byte_next = RESPONSE_START;
              out_last_next = 1'b0;
              out_err_next  = 1'b0;
              state_next    = B_SEND;
              idx_next      = IDX_W'(1);
              sum_next      = 8'h00;
            end
          end
        end
        B_SEND: begin
          out_valid_next = 1'b1;
          out_byte_next  = cur_byte;
          out_last_next  = (idx == LAST_IDX);
          out_err_next   = 1'b0;
          sum_next       = sum + cur_byte;
          idx_next       = idx + 1'b1;
          if (idx == LAST_IDX) state_next = B_IDLE;
        end
        default: state_next = B_IDLE;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sum      <= sum_next;
    out_byte <= out_byte_next;
    out_last <= out_last_next;
    out_err  <= out_err_next;
    out_code <= out_code_next;
  end

endmodule

/* rtl/panel_request_responder_top.sv */
// Panel request responder top level: configuration registers, parser front,
// command queue and response sequencer. Uses prr_pkg and the prr_* modules.
//
//   port group | dir | payload (low bit first)
//   s_*        | in  | tdata: rx_byte[7:0]
//   m_*        | out | tdata: tx_byte[7:0], request_code[23:8]; tlast: last_of_frame;
//              |     | tuser: checksum_error
//   cfg_*      | in  | cfg_index selects the register, cfg_data its value
//
// Input bytes are taken one per cycle unless the queue is full; a request's sum byte
// passes the queue and output register to a first result; then one result per cycle
// unless stalled, so the sequencer sets the rate (six results per five input bytes).
// The two-entry command queue lets the parser run ahead of a stalled output.
// rst is synchronous and clears the parser, queue, sequencer and registers.
module panel_request_responder_top
  import prr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // rx_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // tx_byte, request_code
  output logic                  m_tlast,   // last_of_frame
  output logic [0:0]            m_tuser,   // checksum_error
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg;
  logic        q_push;
  cmd_t        q_push_cmd;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  cmd_t        q_head;
  logic [7:0]  tx_byte;
  logic [15:0] tx_code;
  logic        tx_err;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.digit0_char     <= 7'd49;
      cfg.digit1_char     <= 7'd50;
      cfg.digit2_char     <= 7'd51;
      cfg.dot_mask        <= 3'd3;
      cfg.screen_on       <= 1'b1;
      cfg.timer_indicator <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIGIT0_CHAR: cfg.digit0_char     <= cfg_data;
        REG_DIGIT1_CHAR: cfg.digit1_char     <= cfg_data;
        REG_DIGIT2_CHAR: cfg.digit2_char     <= cfg_data;
        REG_DOT_MASK:    cfg.dot_mask        <= cfg_data[2:0];
        REG_SCREEN_ON:   cfg.screen_on       <= cfg_data[0];
        REG_TIMER_IND:   cfg.timer_indicator <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Request parser
  prr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  // Command queue
  prr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Response sequencer
  prr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (tx_byte),
    .out_last  (m_tlast),
    .out_err   (tx_err),
    .out_code  (tx_code)
  );

  assign m_tdata    = {tx_code, tx_byte};
  assign m_tuser[0] = tx_err;

`ifndef SYNTHESIS
  // The parser never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("command queue overflow");

  // The sequencer never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command queue underflow");

  // An error result is always a single-item run with a zero byte
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tlast && (m_tdata[7:0] == 8'h00)))
    else $error("error result malformed");

  // A good command popped from the queue starts its response frame with the start byte
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    (q_pop && !q_head.err) |=> (m_tvalid && (m_tdata[7:0] == RESPONSE_START)))
    else $error("response frame did not start with start byte");
`endif

endmodule

/* sim/panel_request_responder_top_tb.sv */
// Testbench for panel_request_responder_top: streams request bytes in, checks every
// response item against an in-bench model of the parser and frame builder.
// Depends on prr_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module panel_request_responder_top_tb;
  import prr_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 12;
  localparam int HOLD_PHASE = 4;
  localparam int DRAIN_PHASE = 7;
  localparam int PHASE_ITEMS = 6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;
  localparam logic [7:0] SCREEN_BIT = 8'h10;
  localparam logic [7:0] TIMER_BIT  = 8'h01;
  localparam string GLYPHS = "0123456789 -AEFHLTRaefhltr";

  // One response item as the block should send it
  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        last_of_frame;
    logic        checksum_error;
    logic [15:0] request_code;
  } frame_byte_t;

  // One byte to send, or a marker that holds the sender until all responses are in
  typedef struct {
    logic [7:0] data;
    bit         drain;
  } rx_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'h00;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [23:0]           m_tdata;
  logic                  m_tlast;
  logic [0:0]            m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  panel_request_responder_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state: display settings and request parser
  logic [6:0] cfg_chars [3];
  logic [2:0] cfg_dots;
  logic       cfg_screen;
  logic       cfg_timer;
  bit         req_open;
  int         req_count;
  logic [7:0] req_bytes [REQUEST_LENGTH-1];

  frame_byte_t tx_expected[$];
  rx_item_t    rx_pending[$];
  int          queued_items = 0;
  int          fail_count = 0;
  int          rx_gap_max = 0;
  int          tx_stall_max = 0;
  bit          rx_offering = 1'b0;
  logic        long_hold_arm = 1'b0;

  // Seven-segment pattern of a character; anything unsupported is blank
  function automatic logic [7:0] glyph_of(input logic [6:0] c);
    logic [7:0] ch;
    logic [7:0] g;
    ch = {1'b0, c};
    if (ch >= "a" && ch <= "z") ch = ch - 8'h20;
    case (ch)
      "0": g = 8'h3f;
      "1": g = 8'h06;
      "2": g = 8'h5b;
      "3": g = 8'h4f;
      "4": g = 8'h66;
      "5": g = 8'h6d;
      "6": g = 8'h7d;
      "7": g = 8'h07;
      "8": g = 8'h7f;
      "9": g = 8'h6f;
      "-": g = 8'h40;
      "A": g = 8'h77;
      "E": g = 8'h79;
      "F": g = 8'h71;
      "H": g = 8'h76;
      "L": g = 8'h38;
      "T": g = 8'h31;
      "R": g = 8'h50;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  task automatic expect_byte(input logic [7:0] tx, input logic last, input logic err,
                             input logic [15:0] code);
    frame_byte_t e;
    e.tx_byte = tx;
    e.last_of_frame = last;
    e.checksum_error = err;
    e.request_code = code;
    tx_expected.insert(tx_expected.size(), e);
  endtask

  // Advance the parser by one received byte and queue the response it causes
  task automatic panel_answer(input logic [7:0] b);
    logic [7:0]  total;
    logic [7:0]  seg;
    logic [7:0]  stat;
    logic [15:0] code;
    int          i;
    if (!req_open) begin
      if (b == HEADER_BYTE) begin
        req_open = 1'b1;
        req_count = 0;
      end
    end else if (req_count < REQUEST_LENGTH - 1) begin
      req_bytes[req_count] = b;
      req_count++;
    end else begin
      total = 8'h00;
      for (i = 0; i < REQUEST_LENGTH - 1; i++) total = total + req_bytes[i];
      code = {req_bytes[1], req_bytes[2]};
      req_open = 1'b0;
      req_count = 0;
      if (total != b) begin
        expect_byte(8'h00, 1'b1, 1'b1, code);
      end else begin
        expect_byte(RESPONSE_START, 1'b0, 1'b0, code);
        total = 8'h00;
        for (i = 0; i < DISPLAY_DIGITS; i++) begin
          seg = glyph_of(cfg_chars[i]) | (cfg_dots[i] ? DOT_BIT : 8'h00);
          total = total + seg;
          expect_byte(seg, 1'b0, 1'b0, code);
        end
        stat = (cfg_screen ? SCREEN_BIT : 8'h00) | (cfg_timer ? TIMER_BIT : 8'h00);
        total = total + stat;
        expect_byte(stat, 1'b0, 1'b0, code);
        expect_byte(total, 1'b1, 1'b0, code);
      end
    end
  endtask

  // Sender: offers queued bytes, with a random gap after each accepted one
  int       rx_gap = 0;
  rx_item_t rx_next;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      rx_offering = 1'b0;
      rx_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        panel_answer(s_tdata);
        rx_offering = 1'b0;
        rx_gap = $urandom_range(0, rx_gap_max);
      end
      if (!rx_offering) begin
        if (rx_gap > 0) begin
          rx_gap--;
        end else if (rx_pending.size() > 0) begin
          if (rx_pending[0].drain) begin
            if (tx_expected.size() == 0) rx_next = rx_pending.pop_front();
          end else begin
            rx_next = rx_pending.pop_front();
            s_tdata <= rx_next.data;
            rx_offering = 1'b1;
          end
        end
      end
      s_tvalid <= rx_offering;
    end
  end

  task automatic check_tx();
    frame_byte_t want;
    if (tx_expected.size() == 0) begin
      $error("unexpected response item: tdata %h tlast %b tuser %b", m_tdata, m_tlast, m_tuser);
      fail_count++;
    end else begin
      want = tx_expected.pop_front();
      if (m_tdata[7:0] !== want.tx_byte) begin
        $error("tx_byte: expected %h, got %h", want.tx_byte, m_tdata[7:0]);
        fail_count++;
      end
      if (m_tlast !== want.last_of_frame) begin
        $error("last_of_frame: expected %b, got %b", want.last_of_frame, m_tlast);
        fail_count++;
      end
      if (m_tuser[0] !== want.checksum_error) begin
        $error("checksum_error: expected %b, got %b", want.checksum_error, m_tuser[0]);
        fail_count++;
      end
      if (m_tdata[23:8] !== want.request_code) begin
        $error("request_code: expected %h, got %h", want.request_code, m_tdata[23:8]);
        fail_count++;
      end
    end
  endtask

  // Receiver: checks each item, then stalls a random count; one long hold-off on request
  int stall_left = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_tx();
        stall_left = $urandom_range(0, tx_stall_max);
      end
      if (long_hold_arm && !long_hold_done) begin
        hold_left = HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    rx_item_t it;
    it.data = b;
    it.drain = 1'b0;
    rx_pending.insert(rx_pending.size(), it);
    queued_items++;
  endtask

  // Header, three request bytes and their sum, optionally spoiled
  task automatic push_frame(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                            input bit corrupt);
    logic [7:0] total;
    total = b0 + b1 + b2;
    if (corrupt) total = total ^ 8'($urandom_range(1, 255));
    push_byte(HEADER_BYTE);
    push_byte(b0);
    push_byte(b1);
    push_byte(b2);
    push_byte(total);
  endtask

  // Request byte, now and then the header value used as data
  function automatic logic [7:0] payload_byte();
    return ($urandom_range(0, 7) == 0) ? HEADER_BYTE : 8'($urandom);
  endfunction

  // Mostly good requests; some bad sums, noise, cut-off requests, doubled headers
  task automatic push_sequence();
    int pick;
    int n;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      push_frame(payload_byte(), payload_byte(), payload_byte(), 1'b0);
    end else if (pick == 6) begin
      push_frame(payload_byte(), payload_byte(), payload_byte(), 1'b1);
    end else if (pick == 7) begin
      n = $urandom_range(1, 3);
      repeat (n) push_byte(8'($urandom));
    end else if (pick == 8) begin
      push_byte(HEADER_BYTE);
      n = $urandom_range(1, 3);
      repeat (n) push_byte(payload_byte());
    end else begin
      push_byte(HEADER_BYTE);
      push_frame(payload_byte(), payload_byte(), payload_byte(), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_DIGIT0_CHAR: cfg_chars[0] = val;
      REG_DIGIT1_CHAR: cfg_chars[1] = val;
      REG_DIGIT2_CHAR: cfg_chars[2] = val;
      REG_DOT_MASK:    cfg_dots = val[2:0];
      REG_SCREEN_ON:   cfg_screen = val[0];
      REG_TIMER_IND:   cfg_timer = val[0];
      default: ;
    endcase
  endtask

  // Phase one clears every setting, phase two sets every bit, the rest are random
  task automatic set_display(input int phase);
    logic [CFG_DATA_W-1:0] v;
    int                    d;
    for (d = 0; d < 3; d++) begin
      if (phase == 1) v = '0;
      else if (phase == 2) v = '1;
      else if ($urandom_range(0, 4) != 0) v = CFG_DATA_W'(GLYPHS[$urandom_range(0, GLYPHS.len() - 1)]);
      else v = CFG_DATA_W'($urandom);
      write_reg(CFG_IDX_W'(REG_DIGIT0_CHAR + d), v);
    end
    v = (phase == 1) ? '0 : (phase == 2) ? '1 : CFG_DATA_W'($urandom);
    write_reg(REG_DOT_MASK, v);
    v = (phase == 1) ? '0 : (phase == 2) ? '1 : CFG_DATA_W'($urandom);
    write_reg(REG_SCREEN_ON, v);
    v = (phase == 1) ? '0 : (phase == 2) ? '1 : CFG_DATA_W'($urandom);
    write_reg(REG_TIMER_IND, v);
    write_reg(REG_UNUSED_A, CFG_DATA_W'($urandom));
    write_reg(REG_UNUSED_B, CFG_DATA_W'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Block is idle once all bytes are taken and every response is back
  task automatic wait_idle();
    while (rx_pending.size() != 0 || rx_offering || tx_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Main sequence
  rx_item_t hold_marker;
  initial begin
    int phase;
    int start;
    cfg_chars[0] = 7'h31;
    cfg_chars[1] = 7'h32;
    cfg_chars[2] = 7'h33;
    cfg_dots = 3'd3;
    cfg_screen = 1'b1;
    cfg_timer = 1'b0;
    req_open = 1'b0;
    req_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part with reset settings: noise, field extremes, bad sum, header as data
    rx_gap_max = 0;
    tx_stall_max = 3;
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(RESPONSE_START);
    push_frame(8'h00, 8'h00, 8'h00, 1'b0);
    push_frame(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_frame(8'h12, 8'h34, 8'h56, 1'b1);
    push_frame(HEADER_BYTE, HEADER_BYTE, HEADER_BYTE, 1'b0);
    wait_idle();

    // Random part, new display settings each phase
    for (phase = 1; phase <= PHASES; phase++) begin
      set_display(phase);
      rx_gap_max = (phase % 3 == 0) ? 0 : 15;
      tx_stall_max = (phase % 4 == 1) ? 0 : 15;
      start = queued_items;
      if (phase == HOLD_PHASE) begin
        repeat (6) push_frame(payload_byte(), payload_byte(), payload_byte(), 1'b0);
        @(posedge clk);
        long_hold_arm <= 1'b1;
      end
      while (queued_items - start < PHASE_ITEMS) push_sequence();
      if (phase == DRAIN_PHASE) begin
        hold_marker.data = 8'h00;
        hold_marker.drain = 1'b1;
        rx_pending.insert(rx_pending.size(), hold_marker);
        repeat (2) push_sequence();
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* panel_request_responder_top.f */
rtl/prr_pkg.sv
rtl/prr_front.sv
rtl/prr_queue.sv
rtl/prr_back.sv
rtl/panel_request_responder_top.sv
sim/panel_request_responder_top_tb.sv
